// ===== sv/pfba_pkg.sv =====
// pfba_pkg: types, codes and constants of the page frame bitmap allocator
// used by page_frame_bitmap_allocator and its bench; no dependencies
`default_nettype none

package pfba_pkg;

    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned LEN_W         = 13;
    localparam int unsigned PAGE_BYTES    = 4096;
    localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int unsigned FIDX_W        = ADDR_W - PAGE_SHIFT;
    localparam int unsigned WORD_BITS     = 64;
    localparam int unsigned WORD_SHIFT    = $clog2(WORD_BITS);
    localparam int unsigned MAX_PAGES_DEF = 4096;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [LEN_W-1:0]     PAGES_RESET = LEN_W'(4096);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ALLOC_ONE = 2'd0,
        KIND_ALLOC_RUN = 2'd1,
        KIND_MARK_RUN  = 2'd2,
        KIND_FREE_ONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ONE_FETCH,
        ST_ONE_EVAL,
        ST_RUN_FETCH,
        ST_RUN_EVAL,
        ST_MARK_STEP,
        ST_MARK_WRITE
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   frame_address;
        logic [LEN_W-1:0]    run_length;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic                success;
    } result_t;

    // mask of the k lowest bits of a map word, k up to the full word
    function automatic logic [WORD_BITS-1:0] ones_below(input logic [WORD_SHIFT:0] k);
        logic [WORD_BITS-1:0] m;
        if (k[WORD_SHIFT])
        begin
            m = '1;
        end
        else
        begin
            m = (WORD_BITS'(1) << k[WORD_SHIFT-1:0]) - WORD_BITS'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pfba_ram.sv =====
// pfba_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
`default_nettype none

module pfba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/page_frame_bitmap_allocator.sv =====
// page_frame_bitmap_allocator: used/free bitmap over a pool of page frames
// depends on pfba_pkg and pfba_ram
//
//   port group   dir   beat marked by           contents
//   cmd          in    start & !busy            kind, frame_address, run_length
//   result       out   done (one cycle)         result_address, success
//   cfg          in    cfg_wr_en                cfg_index selects, cfg_wdata
//
// the map sits in a ram of 64-frame words, searched by one find-first unit
// allocate one: fetch and evaluate each map word from the hint word to the hit
// allocate run: fetch and evaluate per word, re-evaluate per free/used boundary,
// then marking; mark run: read and write per map word touched, a skip step on wrap
// free one: read, write; after reset a clearing pass zeroes the map, busy high
// result is registered and shown for one cycle; the receiver cannot stall
`default_nettype none

module page_frame_bitmap_allocator #(
    parameter int unsigned MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pfba_pkg::cmd_t                    cmd,
    output logic                              done,
    output pfba_pkg::result_t                 result,
    input  logic                              cfg_wr_en,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import pfba_pkg::*;

    localparam int unsigned ROWS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned GW    = ROW_W + WORD_SHIFT;
    localparam int unsigned CNT_W = $clog2(MAX_PAGES + 1);
    localparam int unsigned MW1   = (FIDX_W > CNT_W) ? FIDX_W : CNT_W;
    localparam int unsigned XW    = ((MW1 > GW) ? MW1 : GW) + 1;
    localparam int unsigned RUN_W = LEN_W + 1;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [LEN_W-1:0]       pages_reg, pages_next;
    logic [GW-1:0]          hint_reg, hint_next;
    logic [XW-1:0]          cur_reg, cur_next;
    logic [RUN_W-1:0]       carry_reg, carry_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    kind_t                  kind_reg, kind_next;
    logic [WORD_BITS-1:0]   mask_reg, mask_next;
    logic [ROW_W-1:0]       wrow_reg, wrow_next;
    logic                   look_free_reg, look_free_next;
    logic [ROW_W-1:0]       clr_row_reg, clr_row_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic                   ram_we, ram_re;
    logic [ROW_W-1:0]       ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]   ram_wdata, rd_data;

    logic [XW-1:0]          n_x, pages_x, nxt_x, start_x, skip_x, in_idx_x;
    logic [FIDX_W-1:0]      in_idx, sum_f;
    logic [ADDR_W-1:0]      in_diff;
    logic [ROW_W-1:0]       cur_row;
    logic [WORD_SHIFT-1:0]  pos;
    logic [XW-1:0]          lim_diff;
    logic [WORD_BITS-1:0]   cur_lim, eff_used, wmask;
    logic [WORD_SHIFT:0]    uu, span, room, stp, end_bit;
    logic [RUN_W-1:0]       avail;
    logic [GW-1:0]          hit_idx;

    logic [WORD_BITS-1:0]   f_vec, f_x, f_low;
    logic [WORD_SHIFT-1:0]  f_idx;
    logic                   f_hit;

    logic                   fin, fin_ok;
    logic [ADDR_W-1:0]      fin_addr;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic [ADDR_W-1:0] base,
                                                     input logic [GW-1:0] idx);
        return base + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

    pfba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS),
        .AW    (ROW_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    // common terms
    always_comb
    begin
        pages_x  = XW'(pages_reg);
        n_x      = (pages_x < XW'(MAX_PAGES)) ? pages_x : XW'(MAX_PAGES);
        cur_row  = cur_reg[GW-1:WORD_SHIFT];
        pos      = cur_reg[WORD_SHIFT-1:0];
        nxt_x    = XW'({cur_row, WORD_SHIFT'(0)}) + XW'(WORD_BITS);
        lim_diff = n_x - XW'({cur_row, WORD_SHIFT'(0)});
        cur_lim  = (lim_diff >= XW'(WORD_BITS)) ? '1 : ones_below(lim_diff[WORD_SHIFT:0]);
        in_diff  = cmd.frame_address - base_reg;
        in_idx   = in_diff[ADDR_W-1:PAGE_SHIFT];
        in_idx_x = XW'(in_idx);
        eff_used = rd_data | ~mask_reg;
    end

    // shared find-first unit
    always_comb
    begin
        f_vec = (state_reg == ST_ONE_EVAL || look_free_reg) ? ~eff_used : eff_used;
        f_x   = f_vec & ({WORD_BITS{1'b1}} << pos);
        f_low = f_x & (~f_x + WORD_BITS'(1));
        f_hit = |f_x;
        f_idx = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (f_low[j])
            begin
                f_idx = f_idx | WORD_SHIFT'(j);
            end
        end
        hit_idx = {cur_row, f_idx};
    end

    // run and mark arithmetic
    always_comb
    begin
        uu      = f_hit ? {1'b0, f_idx} : (WORD_SHIFT + 1)'(WORD_BITS);
        span    = uu - {1'b0, pos};
        avail   = carry_reg + RUN_W'(span);
        start_x = cur_reg - XW'(carry_reg);
        room    = (WORD_SHIFT + 1)'(WORD_BITS) - {1'b0, pos};
        stp     = (rem_reg < LEN_W'(room)) ? rem_reg[WORD_SHIFT:0] : room;
        end_bit = {1'b0, pos} + stp;
        wmask   = ({WORD_BITS{1'b1}} << pos) & ones_below(end_bit) & cur_lim;
        sum_f   = cur_reg[FIDX_W-1:0] + FIDX_W'(stp);
        skip_x  = (XW'(1) << FIDX_W) - cur_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        pages_next     = pages_reg;
        hint_next      = hint_reg;
        cur_next       = cur_reg;
        carry_next     = carry_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        kind_next      = kind_reg;
        mask_next      = mask_reg;
        wrow_next      = wrow_reg;
        look_free_next = look_free_reg;
        clr_row_next   = clr_row_reg;
        res_addr_next  = res_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_row;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = cur_row;
        fin            = 1'b0;
        fin_ok         = 1'b0;
        fin_addr       = '0;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:    base_next  = cfg_wdata;
                CFG_PAGES_IN_USE: pages_next = cfg_wdata[LEN_W-1:0];
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_row_reg;
                ram_wdata    = '0;
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = cmd.kind;
                    len_next      = cmd.run_length;
                    res_addr_next = '0;
                    unique case (cmd.kind)
                        KIND_ALLOC_ONE:
                        begin
                            if (XW'(hint_reg) >= n_x)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                cur_next   = XW'(hint_reg);
                                state_next = ST_ONE_FETCH;
                            end
                        end
                        KIND_ALLOC_RUN:
                        begin
                            if (cmd.run_length == '0 || n_x == '0)
                            begin
                                fin      = 1'b1;
                                fin_ok   = (n_x != '0) && (cmd.run_length == '0);
                                fin_addr = fin_ok ? base_reg : '0;
                            end
                            else
                            begin
                                cur_next       = '0;
                                carry_next     = '0;
                                look_free_next = 1'b0;
                                state_next     = ST_RUN_FETCH;
                            end
                        end
                        KIND_MARK_RUN:
                        begin
                            cur_next   = in_idx_x;
                            rem_next   = cmd.run_length;
                            state_next = ST_MARK_STEP;
                        end
                        KIND_FREE_ONE:
                        begin
                            if (in_idx_x < n_x)
                            begin
                                if (in_idx_x < XW'(hint_reg))
                                begin
                                    hint_next = in_idx[GW-1:0];
                                end
                                ram_re     = 1'b1;
                                ram_raddr  = in_idx[GW-1:WORD_SHIFT];
                                wrow_next  = in_idx[GW-1:WORD_SHIFT];
                                mask_next  = WORD_BITS'(1) << in_idx[WORD_SHIFT-1:0];
                                rem_next   = '0;
                                state_next = ST_MARK_WRITE;
                            end
                            else
                            begin
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_ONE_FETCH, ST_RUN_FETCH:
            begin
                ram_re     = 1'b1;
                mask_next  = cur_lim;
                state_next = (state_reg == ST_ONE_FETCH) ? ST_ONE_EVAL : ST_RUN_EVAL;
            end
            ST_ONE_EVAL:
            begin
                if (f_hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_data | f_low;
                    hint_next = hit_idx;
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_addr  = frame_addr(base_reg, hit_idx);
                end
                else if (nxt_x >= n_x)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    cur_next   = nxt_x;
                    state_next = ST_ONE_FETCH;
                end
            end
            ST_RUN_EVAL:
            begin
                if (!look_free_reg && avail >= RUN_W'(len_reg))
                begin
                    res_addr_next = frame_addr(base_reg, start_x[GW-1:0]);
                    cur_next      = start_x;
                    rem_next      = len_reg;
                    state_next    = ST_MARK_STEP;
                end
                else if (f_hit)
                begin
                    cur_next       = XW'(hit_idx);
                    carry_next     = '0;
                    look_free_next = !look_free_reg;
                end
                else
                begin
                    // word exhausted: a free run carries over, a used tail does not
                    carry_next     = look_free_reg ? '0 : avail;
                    look_free_next = 1'b0;
                    if (nxt_x >= n_x)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        cur_next   = nxt_x;
                        state_next = ST_RUN_FETCH;
                    end
                end
            end
            ST_MARK_STEP:
            begin
                if (rem_reg == '0)
                begin
                    fin      = 1'b1;
                    fin_ok   = 1'b1;
                    fin_addr = res_addr_reg;
                end
                else if (cur_reg >= n_x)
                begin
                    // out of range frames are skipped until the index wraps
                    if (XW'(rem_reg) <= skip_x)
                    begin
                        fin      = 1'b1;
                        fin_ok   = 1'b1;
                        fin_addr = res_addr_reg;
                    end
                    else
                    begin
                        rem_next = rem_reg - skip_x[LEN_W-1:0];
                        cur_next = '0;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    wrow_next  = cur_row;
                    mask_next  = wmask;
                    cur_next   = XW'(sum_f);
                    rem_next   = rem_reg - LEN_W'(stp);
                    state_next = ST_MARK_WRITE;
                end
            end
            ST_MARK_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wrow_reg;
                ram_wdata  = (kind_reg == KIND_FREE_ONE) ? (rd_data & ~mask_reg)
                                                         : (rd_data | mask_reg);
                state_next = ST_MARK_STEP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        done_next   = fin;
        result_next = result_reg;
        if (fin)
        begin
            state_next  = ST_IDLE;
            result_next = '{result_address: fin_addr, success: fin_ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            base_reg      <= '0;
            pages_reg     <= PAGES_RESET;
            hint_reg      <= '0;
            look_free_reg <= 1'b0;
            clr_row_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            pages_reg     <= pages_next;
            hint_reg      <= hint_next;
            look_free_reg <= look_free_next;
            clr_row_reg   <= clr_row_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        carry_reg    <= carry_next;
        rem_reg      <= rem_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        mask_reg     <= mask_next;
        wrow_reg     <= wrow_next;
        res_addr_reg <= res_addr_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a result beat only follows an accepted request or running work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a request");

    // hint stays inside the map
    assert property (@(posedge clk) disable iff (!rst_n)
        XW'(hint_reg) < XW'(MAX_PAGES))
        else $error("search hint outside the map");

    // allocate one sets exactly one bit of the word it writes back
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ONE_EVAL && ram_we) |-> $onehot(ram_wdata ^ rd_data))
        else $error("allocate one changed other than one frame");

    // a carried run is always shorter than the run asked for
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_EVAL) |-> (carry_reg < RUN_W'(len_reg)))
        else $error("run carry reached the requested length");

    // no map traffic from the search while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!ram_re && !done))
        else $error("activity during the clearing pass");

endmodule

`default_nettype wire

// ===== sim/page_frame_bitmap_allocator_test.sv =====
`timescale 1ns / 100ps
// page_frame_bitmap_allocator_test: self-checking bench for the page frame bitmap allocator
// queues request beats, predicts each result from its own copy of the frame map and compares
// depends on pfba_pkg and page_frame_bitmap_allocator

module page_frame_bitmap_allocator_test;
    import pfba_pkg::*;

    localparam int unsigned MAP_DEPTH   = MAX_PAGES_DEF;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned SHOW_LIMIT  = 10;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cmd_t                  cmd       = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit          frame_taken [MAP_DEPTH];
    int unsigned scan_hint      = 0;
    logic [31:0] base_reg       = '0;
    logic [12:0] page_count_reg = PAGES_RESET;

    cmd_t        pending_cmds [$];
    result_t     expected_results [$];
    int unsigned items_queued;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned grants;
    int unsigned refusals;
    int unsigned settings_used;
    bit          cmd_taken;

    page_frame_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned managed_frames();
        return (page_count_reg < MAP_DEPTH) ? page_count_reg : MAP_DEPTH;
    endfunction

    function automatic logic [31:0] frame_to_addr(int unsigned idx);
        return base_reg + (32'(idx) << PAGE_SHIFT);
    endfunction

    function automatic logic [31:0] addr_to_frame(logic [31:0] a);
        return (a - base_reg) >> PAGE_SHIFT;
    endfunction

    task automatic apply_request(input cmd_t c, output result_t r);
        int unsigned n;
        int unsigned i;
        int unsigned k;
        int unsigned span;
        int unsigned first;
        int unsigned len;
        logic [31:0] idx;
        bit          found;
        n = managed_frames();
        len = c.run_length;
        found = 1'b0;
        r.result_address = '0;
        r.success = 1'b1;
        case (c.kind)
            KIND_ALLOC_ONE:
            begin
                for (i = scan_hint; i < n && !found; i++)
                begin
                    if (!frame_taken[i])
                    begin
                        frame_taken[i] = 1'b1;
                        scan_hint = i;
                        r.result_address = frame_to_addr(i);
                        found = 1'b1;
                    end
                end
                r.success = found;
            end
            KIND_ALLOC_RUN:
            begin
                if (len == 0)
                begin
                    found = (n > 0);
                    if (found)
                        r.result_address = frame_to_addr(0);
                end
                else
                begin
                    span = 0;
                    for (i = 0; i < n && !found; i++)
                    begin
                        span = frame_taken[i] ? 0 : span + 1;
                        if (span == len)
                        begin
                            first = i + 1 - len;
                            for (k = first; k <= i; k++)
                                frame_taken[k] = 1'b1;
                            r.result_address = frame_to_addr(first);
                            found = 1'b1;
                        end
                    end
                end
                r.success = found;
            end
            KIND_MARK_RUN:
            begin
                for (k = 0; k < len; k++)
                begin
                    idx = addr_to_frame(c.frame_address + (32'(k) << PAGE_SHIFT));
                    if (idx < n)
                        frame_taken[idx] = 1'b1;
                end
            end
            default:
            begin
                idx = addr_to_frame(c.frame_address);
                if (idx < n)
                begin
                    if (idx < scan_hint)
                        scan_hint = idx;
                    frame_taken[idx] = 1'b0;
                end
            end
        endcase
    endtask

    task automatic queue_cmd(input kind_t k, input logic [31:0] a, input int unsigned len);
        cmd_t c;
        c.kind = k;
        c.frame_address = a;
        c.run_length = LEN_W'(len);
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    // frame address, sometimes pointing inside the frame
    function automatic logic [31:0] pick_addr(int unsigned idx);
        return frame_to_addr(idx) + (($urandom_range(3) == 0) ? $urandom_range(4095) : 0);
    endfunction

    task automatic queue_random_sequence();
        int unsigned n;
        int unsigned sel;
        int unsigned reps;
        int unsigned first;
        int unsigned j;
        int unsigned len;
        n = managed_frames();
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            queue_cmd(kind_t'($urandom_range(3)), $urandom, $urandom_range(4096));
        end
        else if (sel < 40)
        begin
            // sweep of frees over neighboring frames
            reps = $urandom_range(12, 1);
            first = $urandom_range(n);
            for (j = 0; j < reps; j++)
                queue_cmd(KIND_FREE_ONE, pick_addr(first + j), $urandom_range(4096));
        end
        else if (sel < 70)
        begin
            reps = $urandom_range(4, 1);
            for (j = 0; j < reps; j++)
                queue_cmd(KIND_ALLOC_ONE, $urandom, $urandom_range(4096));
        end
        else if (sel < 90)
        begin
            sel = $urandom_range(19);
            len = (sel == 0) ? $urandom_range(4096) : (sel == 1) ? n : $urandom_range(8);
            queue_cmd(KIND_ALLOC_RUN, $urandom, len);
        end
        else
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(4096) : $urandom_range(6);
            queue_cmd(KIND_MARK_RUN,
                      ($urandom_range(3) == 0) ? $urandom : pick_addr($urandom_range(n)), len);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_POOL_BASE)
            base_reg = value;
        else
            page_count_reg = value[12:0];
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [31:0] base, input int unsigned pages,
                             input int unsigned idle_pct, input int unsigned count);
        int unsigned goal;
        wait_drained();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_PAGES_IN_USE, pages);
        settings_used++;
        send_idle_pct = idle_pct;
        goal = items_queued + count;
        while (items_queued < goal)
            queue_random_sequence();
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_taken))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd   <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // accept and result monitor
    always @(posedge clk)
    begin : sample_beats
        result_t want;
        cmd_taken = rst_n && start && !busy;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected result beat at cycle %0d: addr %h success %b",
                             cycle_count, result.result_address, result.success);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.result_address !== want.result_address ||
                    result.success !== want.success)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("bad result at cycle %0d: expected %h/%b, got %h/%b",
                                 cycle_count, want.result_address, want.success,
                                 result.result_address, result.success);
                end
            end
        end
        if (cmd_taken)
        begin
            apply_request(cmd, want);
            expected_results.push_back(want);
            if (cmd.kind == KIND_ALLOC_ONE || cmd.kind == KIND_ALLOC_RUN)
            begin
                if (want.success)
                    grants++;
                else
                    refusals++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_queued);
            $display("page_frame_bitmap_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full pool after reset: whole-map run, hint movement, out of range frees, wrap
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 4096);
        queue_cmd(KIND_ALLOC_ONE, 32'hFFFF_FFFF, 0);
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 0);
        queue_cmd(KIND_FREE_ONE, 32'h0000_5000, 0);
        queue_cmd(KIND_ALLOC_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_FREE_ONE, 32'h0000_3FFF, 0);
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 2);
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 1);
        queue_cmd(KIND_FREE_ONE, 32'h00FF_F000, 0);
        queue_cmd(KIND_FREE_ONE, 32'h0100_0000, 0);
        queue_cmd(KIND_ALLOC_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_FREE_ONE, 32'hFFFF_F000, 4096);
        queue_cmd(KIND_FREE_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_FREE_ONE, 32'h0000_1000, 0);
        queue_cmd(KIND_MARK_RUN, 32'hFFFF_E000, 4);
        queue_cmd(KIND_ALLOC_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_MARK_RUN, 32'h0000_2000, 0);

        // empty pool
        wait_drained();
        write_reg(CFG_PAGES_IN_USE, 32'd0);
        settings_used++;
        queue_cmd(KIND_ALLOC_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 0);
        queue_cmd(KIND_FREE_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_MARK_RUN, 32'h0000_0000, 3);

        // page count above map depth, base near the top of the address space
        wait_drained();
        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        write_reg(CFG_PAGES_IN_USE, 32'd8191);
        settings_used++;
        queue_cmd(KIND_FREE_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_ALLOC_ONE, 32'h0000_0000, 0);
        queue_cmd(KIND_ALLOC_RUN, 32'h0000_0000, 4096);

        run_phase($urandom, 64, 0, 150);
        run_phase(32'h0000_0000, 4096, 59, 150);
        run_phase(32'hFFFF_FFFF, 1, 19, 80);
        run_phase($urandom, 200, 0, 150);
        run_phase($urandom, 4096, 19, 150);
        run_phase(32'h8000_0000, 2, 59, 80);
        run_phase($urandom, 100, 19, 150);
        run_phase(32'h0000_0000, 8191, 0, 100);
        run_phase($urandom, 0, 59, 40);
        run_phase($urandom, 1000, 19, 100);

        wait_drained();
        repeat (50) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            mismatch_count += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("ran %0d requests under %0d pool settings in %0d cycles",
                 items_queued, settings_used, cycle_count);
        $display("allocations granted %0d, refused %0d, bad beats %0d",
                 grants, refusals, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("page_frame_bitmap_allocator: match");
        end
        else
        begin
            $display("page_frame_bitmap_allocator: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pfba_pkg.sv
sv/pfba_ram.sv
sv/page_frame_bitmap_allocator.sv
sim/page_frame_bitmap_allocator_test.sv
